// File: hw/rtl/tcs_pkg.sv
// Shared types and constants for the card channel splitter.
package tcs_pkg;

    localparam int WORD_W     = 16;
    localparam int CHAN_IDX_W = 6;
    localparam int TOTAL_W    = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int C_CHANNELS = 64;
    localparam int Q_DEPTH    = 4;

    localparam logic [WORD_W-1:0] HEADER_BASE_RST  = 16'h4000;
    localparam logic [WORD_W-1:0] TRAILER_BASE_RST = 16'h5000;
    localparam logic [WORD_W-1:0] MIN_WORDS_RST    = 16'h0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HEADER_BASE       = 2'd0,
        REG_TRAILER_BASE      = 2'd1,
        REG_MIN_CHANNEL_WORDS = 2'd2
    } t_reg_index;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_BAD_HEADER   = 2'd1,
        ST_TRUNCATED    = 2'd2,
        ST_UNTERMINATED = 2'd3
    } t_status;

    typedef struct packed {
        logic [WORD_W-1:0]     out_word;
        logic [CHAN_IDX_W-1:0] channel_index;
        logic                  channel_end;
        logic                  card_end;
        logic                  trailer_missing;
        t_status               status;
        logic [TOTAL_W-1:0]    channel_total;
    } t_result;

    typedef struct packed {
        logic    push0;
        logic    push1;
        t_result res0;
        t_result res1;
    } t_push;

endpackage

// File: hw/rtl/tcs_ifaces.sv
// Handshake interfaces for the word, result and configuration channels.
interface tcs_word_if import tcs_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] data_word;
    logic              card_last;

    modport source (output valid, output data_word, output card_last, input ready);
    modport sink (input valid, input data_word, input card_last, output ready);
endinterface

interface tcs_result_if import tcs_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [WORD_W-1:0]     out_word;
    logic [CHAN_IDX_W-1:0] channel_index;
    logic                  channel_end;
    logic                  card_end;
    logic                  trailer_missing;
    logic [1:0]            status;
    logic [TOTAL_W-1:0]    channel_total;

    modport source (
        output valid, output out_word, output channel_index, output channel_end,
        output card_end, output trailer_missing, output status, output channel_total,
        input ready
    );
    modport sink (
        input valid, input out_word, input channel_index, input channel_end,
        input card_end, input trailer_missing, input status, input channel_total,
        output ready
    );
endinterface

interface tcs_cfg_if import tcs_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/tpc_card_channel_splitter_core.sv
// Top level of the card channel splitter.
// The word channel takes one raw card word per beat, with card_last on the final word of a
// card. The result channel returns each word that is not dropped after a bad header or
// the last channel, tagged with its channel, channel and card end marks, a missing-trailer
// flag, a status code and the channel count on the card end beat. The configuration
// channel writes the header base, trailer base and minimum remainder; it is always ready
// and should only be written while no words are in flight. The block sustains one word
// per clock while the result queue has room. A word is held back by one word so that a
// trailer can be matched against the following header; its result enters the queue when
// the releasing word is accepted, a final word's when it is accepted. The four-entry result
// queue sets the input ready, which drops only when fewer than two entries are free, so a
// stalled receiver backs up into the word channel once three results wait in the queue
// behind the output register. Reset clears the channel state, the queue and the output
// register, and loads the default bases.
module tpc_card_channel_splitter_core import tcs_pkg::*; #(
    parameter int CHANNELS = C_CHANNELS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tcs_word_if.sink      i_word,
    tcs_result_if.source  o_result,
    tcs_cfg_if.sink       i_cfg
);

    t_push   push;
    logic    room;
    logic    q_valid;
    t_result q_data;
    logic    pop;

    tcs_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_word  (i_word),
        .i_cfg   (i_cfg),
        .i_room  (room),
        .o_push  (push)
    );

    tcs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_room  (room),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    tcs_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_data   (q_data),
        .o_pop    (pop),
        .o_result (o_result)
    );

endmodule

// File: hw/rtl/tcs_front.sv
// Front end: accepts words, tracks channel framing and produces up to two results per beat.
module tcs_front import tcs_pkg::*; #(
    parameter int CHANNELS = C_CHANNELS
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    tcs_word_if.sink i_word,
    tcs_cfg_if.sink  i_cfg,
    input  logic     i_room,
    output t_push    o_push
);

    localparam int CW = $clog2(CHANNELS + 1);
    localparam logic [CW-1:0] LAST_CH = CW'(CHANNELS - 1);
    localparam logic [CW-1:0] END_CH  = CW'(CHANNELS);

    logic [WORD_W-1:0] r_header_base;
    logic [WORD_W-1:0] r_trailer_base;
    logic [WORD_W-1:0] r_min_words;
    logic [CW-1:0]     r_cur, n_cur;
    logic [CW-1:0]     r_done, n_done;
    logic              r_expect, n_expect;
    logic              r_hv, n_hv;
    logic              r_err, n_err;
    logic [WORD_W-1:0] r_wsc, n_wsc;
    logic [WORD_W-1:0] r_held;

    logic              accept;
    logic              hold;
    logic [WORD_W-1:0] w;
    logic              last;
    logic [WORD_W-1:0] cur_ext;
    logic [WORD_W-1:0] hdr_cur, hdr_nxt, trl_cur, trl_nxt;
    logic              push_h, push_w;
    t_result           res_h, res_w;

    function automatic logic short_rest(input logic [WORD_W-1:0] r,
                                        input logic [WORD_W-1:0] min_w);
        return (r != '0) && (r < min_w);
    endfunction

    function automatic logic [WORD_W-1:0] sat_inc(input logic [WORD_W-1:0] v);
        return (v == '1) ? v : v + WORD_W'(1);
    endfunction

    function automatic t_result mk_res(input logic [WORD_W-1:0] word,
                                       input logic [CW-1:0] chan, input logic cend);
        t_result r;
        r               = '0;
        r.out_word      = word;
        r.channel_index = CHAN_IDX_W'(chan);
        r.channel_end   = cend;
        r.status        = ST_OK;
        return r;
    endfunction

    assign i_word.ready = i_room;
    assign i_cfg.ready  = 1'b1;
    assign accept       = i_word.valid && i_room;
    assign w            = i_word.data_word;
    assign last         = i_word.card_last;

    assign cur_ext = WORD_W'(r_cur);
    assign hdr_cur = r_header_base + cur_ext;
    assign hdr_nxt = hdr_cur + WORD_W'(1);
    assign trl_cur = r_trailer_base + cur_ext;
    assign trl_nxt = trl_cur + WORD_W'(1);

    always_comb begin
        logic [CW-1:0]     cur_t;
        logic [CW-1:0]     done_t;
        logic [CW-1:0]     done_f;
        logic [WORD_W-1:0] wsc_t;
        logic [WORD_W-1:0] trl_t;
        logic              cl_h;
        logic              cl_l;
        logic              go;
        logic              card_done;

        n_cur     = r_cur;
        n_done    = r_done;
        n_expect  = r_expect;
        n_hv      = r_hv;
        n_err     = r_err;
        n_wsc     = r_wsc;
        push_h    = 1'b0;
        push_w    = 1'b0;
        res_h     = '0;
        res_w     = '0;
        hold      = 1'b0;
        cur_t     = r_cur;
        done_t    = r_done;
        done_f    = r_done;
        wsc_t     = r_wsc;
        trl_t     = trl_cur;
        cl_h      = 1'b0;
        cl_l      = 1'b0;
        go        = 1'b0;
        card_done = 1'b0;

        if (accept) begin
            if (r_err) begin
                if (last) begin
                    push_w              = 1'b1;
                    res_w               = mk_res(w, r_cur, 1'b0);
                    res_w.card_end      = 1'b1;
                    res_w.status        = ST_BAD_HEADER;
                    res_w.channel_total = TOTAL_W'(r_done);
                    card_done           = 1'b1;
                end
            end else if (r_cur == END_CH) begin
                wsc_t = sat_inc(r_wsc);
                n_wsc = wsc_t;
                if (last) begin
                    push_w              = 1'b1;
                    res_w               = mk_res(w, LAST_CH, 1'b0);
                    res_w.card_end      = 1'b1;
                    res_w.status        = short_rest(wsc_t, r_min_words) ? ST_TRUNCATED : ST_OK;
                    res_w.channel_total = TOTAL_W'(r_done);
                    card_done           = 1'b1;
                end
            end else begin
                go = 1'b1;
                if (r_expect) begin
                    if (w != hdr_cur) begin
                        go           = 1'b0;
                        push_w       = 1'b1;
                        res_w        = mk_res(w, r_cur, 1'b0);
                        res_w.status = ST_BAD_HEADER;
                        if (last) begin
                            res_w.card_end      = 1'b1;
                            res_w.channel_total = TOTAL_W'(r_done);
                            card_done           = 1'b1;
                        end else begin
                            n_err = 1'b1;
                        end
                    end else begin
                        n_expect = 1'b0;
                    end
                end else if (r_hv) begin
                    cl_h   = (r_held == trl_cur) && (w == hdr_nxt);
                    push_h = 1'b1;
                    res_h  = mk_res(r_held, r_cur, cl_h);
                    n_hv   = 1'b0;
                    if (cl_h) begin
                        cur_t  = r_cur + CW'(1);
                        done_t = r_done + CW'(1);
                        wsc_t  = '0;
                        trl_t  = trl_nxt;
                    end
                end
                if (go) begin
                    wsc_t  = sat_inc(wsc_t);
                    done_f = done_t + CW'(1);
                    if (cur_t == LAST_CH) begin
                        cl_l   = (w == trl_t);
                        push_w = 1'b1;
                        res_w  = mk_res(w, cur_t, cl_l);
                        if (last) begin
                            res_w.channel_end     = 1'b1;
                            res_w.card_end        = 1'b1;
                            res_w.trailer_missing = !cl_l;
                            res_w.status          = ((done_f > CW'(1)) &&
                                                     short_rest(wsc_t, r_min_words)) ?
                                                    ST_TRUNCATED : ST_OK;
                            res_w.channel_total   = TOTAL_W'(done_f);
                            card_done             = 1'b1;
                        end else begin
                            n_cur  = cl_l ? cur_t + CW'(1) : cur_t;
                            n_done = cl_l ? done_f : done_t;
                            n_wsc  = cl_l ? '0 : wsc_t;
                        end
                    end else if (last) begin
                        push_w              = 1'b1;
                        res_w               = mk_res(w, cur_t, 1'b0);
                        res_w.card_end      = 1'b1;
                        res_w.status        = ((done_t != '0) &&
                                               short_rest(wsc_t, r_min_words)) ?
                                              ST_TRUNCATED : ST_UNTERMINATED;
                        res_w.channel_total = TOTAL_W'(done_t);
                        card_done           = 1'b1;
                    end else begin
                        hold   = 1'b1;
                        n_hv   = 1'b1;
                        n_cur  = cur_t;
                        n_done = done_t;
                        n_wsc  = wsc_t;
                    end
                end
            end

            if (card_done) begin
                n_cur    = '0;
                n_done   = '0;
                n_expect = 1'b1;
                n_hv     = 1'b0;
                n_err    = 1'b0;
                n_wsc    = '0;
            end
        end
    end

    always_comb begin
        o_push.push0 = push_h || push_w;
        o_push.push1 = push_h && push_w;
        o_push.res0  = push_h ? res_h : res_w;
        o_push.res1  = res_w;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_base  <= HEADER_BASE_RST;
            r_trailer_base <= TRAILER_BASE_RST;
            r_min_words    <= MIN_WORDS_RST;
            r_cur          <= '0;
            r_done         <= '0;
            r_expect       <= 1'b1;
            r_hv           <= 1'b0;
            r_err          <= 1'b0;
            r_wsc          <= '0;
        end else begin
            r_cur    <= n_cur;
            r_done   <= n_done;
            r_expect <= n_expect;
            r_hv     <= n_hv;
            r_err    <= n_err;
            r_wsc    <= n_wsc;
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    REG_HEADER_BASE:       r_header_base  <= i_cfg.data;
                    REG_TRAILER_BASE:      r_trailer_base <= i_cfg.data;
                    REG_MIN_CHANNEL_WORDS: r_min_words    <= i_cfg.data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (hold) begin
            r_held <= w;
        end
    end

endmodule

// File: hw/rtl/tcs_queue.sv
// Short result queue that takes up to two entries and releases one per cycle when popped.
module tcs_queue import tcs_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    input  logic    i_pop,
    output logic    o_room,
    output logic    o_valid,
    output t_result o_data
);

    localparam int PW   = $clog2(Q_DEPTH);
    localparam int CNTW = $clog2(Q_DEPTH + 1);

    t_result         r_mem [Q_DEPTH];
    logic [PW-1:0]   r_wr, n_wr;
    logic [PW-1:0]   r_rd, n_rd;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic            pop;

    assign o_room  = r_cnt <= CNTW'(Q_DEPTH - 2);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rd];
    assign pop     = i_pop && o_valid;

    always_comb begin
        n_wr  = r_wr + PW'(i_push.push0) + PW'(i_push.push1);
        n_rd  = r_rd + PW'(pop);
        n_cnt = r_cnt + CNTW'(i_push.push0) + CNTW'(i_push.push1) - CNTW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push0) begin
            r_mem[r_wr] <= i_push.res0;
        end
        if (i_push.push1) begin
            r_mem[r_wr + PW'(1)] <= i_push.res1;
        end
    end

endmodule

// File: hw/rtl/tcs_back.sv
// Back end: output register that presents one result beat at a time.
module tcs_back import tcs_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  t_result         i_data,
    output logic            o_pop,
    tcs_result_if.source    o_result
);

    logic    r_valid;
    t_result r_data;

    assign o_pop = i_valid && (!r_valid || o_result.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= i_data;
        end
    end

    assign o_result.valid           = r_valid;
    assign o_result.out_word        = r_data.out_word;
    assign o_result.channel_index   = r_data.channel_index;
    assign o_result.channel_end     = r_data.channel_end;
    assign o_result.card_end        = r_data.card_end;
    assign o_result.trailer_missing = r_data.trailer_missing;
    assign o_result.status          = r_data.status;
    assign o_result.channel_total   = r_data.channel_total;

endmodule

// File: hw/rtl/tcs_checker.sv
// Port-level checks for the card channel splitter and their binding to the top level.
module tcs_checker import tcs_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_card_end,
    input logic       i_trailer_missing,
    input logic [1:0] i_status,
    input logic [6:0] i_channel_total
);

    a_idle_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("Result beat presented straight after reset.");

    a_missing_on_card_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_trailer_missing |-> i_card_end && (i_status != ST_UNTERMINATED))
        else $error("Missing trailer flagged outside a properly closed card end.");

    a_mid_card_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_card_end |->
            (i_channel_total == '0) && ((i_status == ST_OK) || (i_status == ST_BAD_HEADER)))
        else $error("Card-end fields set on a beat inside a card.");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("Result beat withdrawn while stalled.");

endmodule

bind tpc_card_channel_splitter_core tcs_checker u_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_out_valid       (o_result.valid),
    .i_out_ready       (o_result.ready),
    .i_card_end        (o_result.card_end),
    .i_trailer_missing (o_result.trailer_missing),
    .i_status          (o_result.status),
    .i_channel_total   (o_result.channel_total)
);
